// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/core/dvw_pkg.sv -----
// constants and helper functions for the date check and weekday pipeline
package dvw_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned CENT_W  = 8;   // year / 100 for any 14-bit year
  localparam int unsigned REM_W   = 7;   // year % 100
  localparam int unsigned SUM_W   = 11;  // widest zeller sum

  // divide by 100 as multiply by ceil(2^19 / 100), exact below 43699
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned DIV100_MUL   = 5243;
  localparam int unsigned DIV100_MUL_W = 13;
  localparam int unsigned PROD_W       = YEAR_W + DIV100_MUL_W;

  localparam logic [YEAR_W-1:0] HUNDRED = YEAR_W'(100);

  localparam logic [4:0] MAX_HOUR = 5'd23;
  localparam logic [5:0] MAX_MIN  = 6'd59;
  localparam logic [5:0] MAX_SEC  = 6'd59;

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_MAR = MONTH_W'(3);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [MONTH_W-1:0] YEAR_SHIFT_MONTHS = MONTH_W'(12);

  // days in a month, february stretched in a leap year
  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      4'd2:                     len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

  // floor(13 * (m + 1) / 5) for the shifted month 3..14
  function automatic logic [5:0] month_term(input logic [MONTH_W-1:0] m);
    logic [5:0] t;
    unique case (m)
      4'd3:    t = 6'd10;
      4'd4:    t = 6'd13;
      4'd5:    t = 6'd15;
      4'd6:    t = 6'd18;
      4'd7:    t = 6'd20;
      4'd8:    t = 6'd23;
      4'd9:    t = 6'd26;
      4'd10:   t = 6'd28;
      4'd11:   t = 6'd31;
      4'd12:   t = 6'd33;
      4'd13:   t = 6'd36;
      4'd14:   t = 6'd39;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  // remainder by 7 using 8 = 1 (mod 7) folding
  function automatic logic [2:0] mod7(input logic [SUM_W-1:0] s);
    logic [4:0] f1;
    logic [3:0] f2;
    logic [2:0] r;
    f1 = 5'(s[2:0]) + 5'(s[5:3]) + 5'(s[8:6]) + 5'(s[10:9]);
    f2 = 4'(f1[2:0]) + 4'(f1[4:3]);
    r  = (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
    return r;
  endfunction

endpackage

// ----- rtl/core/date_validate_and_weekday.sv -----
// date and time validity check with zeller weekday, four-stage pipeline
//
// Checks one timestamp (hour, minute, second, day, month, year) for a valid
// Gregorian date and time and gives its weekday, 0 = Sunday; the weekday is 0
// when the timestamp is invalid. Valid/ready on both sides; one transfer per
// cycle in and out at full rate while the output is not stalled. An input
// transfer reaches out_valid through the four pipeline registers: divide by
// 100 (reciprocal multiply), leap and month-length check, zeller sum, mod 7
// into the output register. A stall on the output backs up stage by stage
// without losing or repeating any transfer.
`include "assert_macros.svh"

module date_validate_and_weekday
  import dvw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [4:0]         hour_in,
  input  logic [5:0]         minute_in,
  input  logic [5:0]         second_in,
  input  logic [DAY_W-1:0]   day_of_month,
  input  logic [MONTH_W-1:0] month_in,
  input  logic [YEAR_W-1:0]  year_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               date_ok,
  output logic [2:0]         weekday
);

  // stage valid bits and load enables
  logic v1, v2, v3, v4;
  logic adv1, adv2, adv3, adv4;

  assign adv4 = !v4 || out_ready;
  assign adv3 = !v3 || adv4;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;
  assign in_ready  = adv1;
  assign out_valid = v4;

  // stage 1 combinational: range checks, year shift, divide by 100
  logic                early;
  logic                ok_in;
  logic [YEAR_W-1:0]   ys_in;
  logic [MONTH_W-1:0]  mm_in;
  logic [PROD_W-1:0]   prod_y, prod_ys;

  always_comb begin
    early = (month_in < MONTH_MAR);
    ok_in = (second_in <= MAX_SEC) && (minute_in <= MAX_MIN) && (hour_in <= MAX_HOUR)
            && (month_in >= MONTH_JAN) && (month_in <= MONTH_DEC)
            && (year_in != '0);
    ys_in   = early ? (year_in - YEAR_W'(1)) : year_in;
    mm_in   = early ? (month_in + YEAR_SHIFT_MONTHS) : month_in;
    prod_y  = PROD_W'(year_in) * PROD_W'(DIV100_MUL);
    prod_ys = PROD_W'(ys_in) * PROD_W'(DIV100_MUL);
  end

  // stage 1 registers
  logic                s1_ok;
  logic [DAY_W-1:0]    s1_day;
  logic [MONTH_W-1:0]  s1_month, s1_mm;
  logic [YEAR_W-1:0]   s1_year, s1_ys;
  logic [CENT_W-1:0]   s1_qy, s1_j;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= in_valid;
    end
    if (adv1 && in_valid) begin
      s1_ok    <= ok_in;
      s1_day   <= day_of_month;
      s1_month <= month_in;
      s1_mm    <= mm_in;
      s1_year  <= year_in;
      s1_ys    <= ys_in;
      s1_qy    <= prod_y[DIV100_SHIFT +: CENT_W];
      s1_j     <= prod_ys[DIV100_SHIFT +: CENT_W];
    end
  end

  // stage 2 combinational: remainders, leap rule, month length
  logic [YEAR_W-1:0]  rem_y_w, k_w;
  logic [REM_W-1:0]   rem_y, k_c;
  logic               leap;
  logic [DAY_W-1:0]   mlen;
  logic               ok_day;

  always_comb begin
    rem_y_w = s1_year - YEAR_W'(s1_qy) * HUNDRED;
    k_w     = s1_ys - YEAR_W'(s1_j) * HUNDRED;
    rem_y   = rem_y_w[REM_W-1:0];
    k_c     = k_w[REM_W-1:0];
    leap    = ((s1_year[1:0] == 2'b00) && (rem_y != '0))
              || ((rem_y == '0) && (s1_qy[1:0] == 2'b00));
    mlen    = month_length(s1_month, leap && (s1_month == MONTH_FEB));
    ok_day  = s1_ok && (s1_day != '0) && (s1_day <= mlen);
  end

  // stage 2 registers
  logic               s2_ok;
  logic [DAY_W-1:0]   s2_day;
  logic [MONTH_W-1:0] s2_mm;
  logic [REM_W-1:0]   s2_k;
  logic [CENT_W-1:0]  s2_j;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= v1;
    end
    if (adv2 && v1) begin
      s2_ok  <= ok_day;
      s2_day <= s1_day;
      s2_mm  <= s1_mm;
      s2_k   <= k_c;
      s2_j   <= s1_j;
    end
  end

  // stage 3: zeller sum d + 13(m+1)/5 + k + k/4 + j/4 + 5j
  logic [SUM_W-1:0] zsum;

  always_comb begin
    zsum = SUM_W'(s2_day) + SUM_W'(month_term(s2_mm)) + SUM_W'(s2_k)
           + SUM_W'(s2_k >> 2) + SUM_W'(s2_j >> 2)
           + SUM_W'({s2_j, 2'b00}) + SUM_W'(s2_j);
  end

  logic             s3_ok;
  logic [SUM_W-1:0] s3_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv3) begin
      v3 <= v2;
    end
    if (adv3 && v2) begin
      s3_ok  <= s2_ok;
      s3_sum <= zsum;
    end
  end

  // stage 4: mod 7, rotate so sunday is 0, mask when invalid
  logic [2:0] h7, wd_next;

  always_comb begin
    h7      = mod7(s3_sum);
    wd_next = !s3_ok ? 3'd0 : ((h7 == 3'd0) ? 3'd6 : (h7 - 3'd1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv4) begin
      v4 <= v3;
    end
    if (adv4 && v3) begin
      date_ok <= s3_ok;
      weekday <= wd_next;
    end
  end

  // checks
  `ASSERT_IMPLIES(a_invalid_day_zero, clk, rst, out_valid && !date_ok, weekday == 3'd0)
  `ASSERT_IMPLIES(a_weekday_range, clk, rst, out_valid, weekday != 3'd7)
  `ASSERT_NEXT(a_accept_fills_s1, clk, rst, in_valid && in_ready, v1)
  `ASSERT_NEXT(a_s1_held_on_stall, clk, rst, v1 && !adv2, v1 && $stable(s1_year))

endmodule

// ----- tb/date_validate_and_weekday_tb.sv -----
// self-checking testbench for the date check and weekday pipeline
module date_validate_and_weekday_tb
  import dvw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LAST_HOUR      = 23;
  localparam int unsigned LAST_MINUTE    = 59;
  localparam int unsigned LAST_SECOND    = 59;
  localparam int unsigned MONTHS_IN_YEAR = 12;
  localparam int unsigned LONG_HOLD      = 60;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 470;
  localparam int unsigned MONTH_DAYS [MONTHS_IN_YEAR] =
    '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } stamp_t;

  typedef struct packed {
    logic       ok;
    logic [2:0] wd;
  } verdict_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [4:0]         hour_in = '0;
  logic [5:0]         minute_in = '0;
  logic [5:0]         second_in = '0;
  logic [DAY_W-1:0]   day_of_month = '0;
  logic [MONTH_W-1:0] month_in = '0;
  logic [YEAR_W-1:0]  year_in = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               date_ok;
  logic [2:0]         weekday;

  stamp_t      pending_stamps[$];
  verdict_t    expected_verdicts[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  logic        hold_request = 1'b0;
  logic        hold_done = 1'b0;
  logic        in_taken = 1'b0;

  date_validate_and_weekday i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .hour_in      (hour_in),
    .minute_in    (minute_in),
    .second_in    (second_in),
    .day_of_month (day_of_month),
    .month_in     (month_in),
    .year_in      (year_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .date_ok      (date_ok),
    .weekday      (weekday)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // gregorian leap rule
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in(input int unsigned m, input int unsigned y);
    int unsigned len;
    len = MONTH_DAYS[m - 1];
    if (m == MONTH_FEB && leap_year(y)) begin
      len = len + 1;
    end
    return len;
  endfunction

  // validity of the whole timestamp and zeller weekday, 0 = sunday
  function automatic verdict_t date_check(input stamp_t s);
    verdict_t    v;
    int unsigned d, m, y, k, c, h;
    v = '0;
    d = s.day;
    m = s.month;
    y = s.year;
    v.ok = (s.second <= LAST_SECOND) && (s.minute <= LAST_MINUTE) &&
           (s.hour <= LAST_HOUR) && (m >= MONTH_JAN) && (m <= MONTH_DEC) && (y > 0);
    if (v.ok) begin
      v.ok = (d >= 1) && (d <= days_in(m, y));
    end
    if (v.ok) begin
      // january and february belong to the year before
      if (m < MONTH_MAR) begin
        m = m + MONTHS_IN_YEAR;
        y = y - 1;
      end
      k = y % 100;
      c = y / 100;
      h = (d + (13 * (m + 1)) / 5 + k + k / 4 + c / 4 + 5 * c) % 7;
      v.wd = 3'((h + 6) % 7);
    end
    return v;
  endfunction

  function automatic stamp_t stamp(input int unsigned h, mi, s, d, mo, y);
    stamp_t t;
    t.hour   = 5'(h);
    t.minute = 6'(mi);
    t.second = 6'(s);
    t.day    = DAY_W'(d);
    t.month  = MONTH_W'(mo);
    t.year   = YEAR_W'(y);
    return t;
  endfunction

  // mostly well-formed timestamps, some with one field broken, some pure noise
  task automatic queue_random(input int unsigned count);
    stamp_t      t;
    int unsigned y, mo, len, pick;
    repeat (count) begin
      case ($urandom_range(7))
        0:       y = $urandom_range(1, 16383);
        1:       y = $urandom_range(1, 163) * 100;
        2:       y = $urandom_range(1, 40) * 400;
        3:       y = $urandom_range(1, 8);
        4:       y = $urandom_range(1, 4095) * 4;
        5:       y = 16383 - $urandom_range(0, 20);
        default: y = $urandom_range(1582, 2100);
      endcase
      mo  = $urandom_range(MONTH_JAN, MONTH_DEC);
      len = days_in(mo, y);
      t = stamp($urandom_range(0, LAST_HOUR), $urandom_range(0, LAST_MINUTE),
                $urandom_range(0, LAST_SECOND), $urandom_range(1, len), mo, y);
      pick = $urandom_range(99);
      if (pick >= 85) begin
        t = stamp($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (pick >= 70) begin
        case ($urandom_range(5))
          0: t.hour   = 5'($urandom_range(LAST_HOUR + 1, 31));
          1: t.minute = 6'($urandom_range(LAST_MINUTE + 1, 63));
          2: t.second = 6'($urandom_range(LAST_SECOND + 1, 63));
          3: t.day    = (len < 31) ? DAY_W'($urandom_range(len + 1, 31)) : '0;
          4: t.month  = ($urandom_range(1) == 0) ? '0 : MONTH_W'($urandom_range(13, 15));
          default: t.year = '0;
        endcase
      end
      pending_stamps.push_back(t);
    end
  endtask

  // sender: offer the next pending timestamp, hold it until the transfer
  always @(negedge clk) begin
    stamp_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_stamps.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_stamps.pop_front();
        in_valid     <= 1'b1;
        hour_in      <= nxt.hour;
        minute_in    <= nxt.minute;
        second_in    <= nxt.second;
        day_of_month <= nxt.day;
        month_in     <= nxt.month;
        year_in      <= nxt.year;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: one long hold-off, otherwise random stalls
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on each input transfer, check each output transfer
  always @(posedge clk) begin
    verdict_t want;
    in_taken <= in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_verdicts.push_back(date_check(stamp(hour_in, minute_in, second_in,
                                                     day_of_month, month_in, year_in)));
      end
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result transfer with nothing expected: date_ok %0d weekday %0d",
                 date_ok, weekday);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          if (date_ok !== want.ok) begin
            $error("date_ok mismatch: expected %0d, actual %0d", want.ok, date_ok);
            fail_count++;
          end
          if (weekday !== want.wd) begin
            $error("weekday mismatch: expected %0d, actual %0d", want.wd, weekday);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // stimulus phases
  initial begin
    // field extremes and out-of-range values
    pending_stamps.push_back(stamp(0, 0, 0, 0, 0, 0));
    pending_stamps.push_back(stamp(31, 63, 63, 31, 15, 16383));
    pending_stamps.push_back(stamp(23, 59, 59, 31, 12, 16383));
    pending_stamps.push_back(stamp(24, 0, 0, 1, 1, 2000));
    pending_stamps.push_back(stamp(0, 60, 0, 1, 1, 2000));
    pending_stamps.push_back(stamp(0, 0, 60, 1, 1, 2000));
    pending_stamps.push_back(stamp(12, 0, 0, 1, 0, 2000));
    pending_stamps.push_back(stamp(12, 0, 0, 1, 13, 2000));
    pending_stamps.push_back(stamp(12, 0, 0, 1, 3, 0));
    pending_stamps.push_back(stamp(12, 0, 0, 0, 6, 2020));
    pending_stamps.push_back(stamp(12, 0, 0, 31, 4, 2021));
    // leap day rules
    pending_stamps.push_back(stamp(8, 30, 0, 29, 2, 2024));
    pending_stamps.push_back(stamp(8, 30, 0, 29, 2, 2000));
    pending_stamps.push_back(stamp(8, 30, 0, 29, 2, 400));
    pending_stamps.push_back(stamp(8, 30, 0, 29, 2, 1900));
    pending_stamps.push_back(stamp(8, 30, 0, 29, 2, 2023));
    pending_stamps.push_back(stamp(8, 30, 0, 28, 2, 1900));
    // first year, where the shifted year becomes zero
    pending_stamps.push_back(stamp(0, 0, 0, 1, 1, 1));
    pending_stamps.push_back(stamp(0, 0, 0, 28, 2, 1));
    pending_stamps.push_back(stamp(0, 0, 0, 1, 3, 1));
    pending_stamps.push_back(stamp(0, 0, 0, 1, 1, 2000));
    pending_stamps.push_back(stamp(16, 32, 32, 13, 9, 2024));
    pending_stamps.push_back(stamp(23, 59, 59, 31, 12, 1999));
    queue_random(PHASE_ITEMS);
    // the receiver holds off at the start while the sender keeps offering
    hold_request = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (pending_stamps.size() == 0 && !in_valid);
    send_idle_pct  = 45;
    recv_stall_pct = 0;
    queue_random(PHASE_ITEMS);

    wait (pending_stamps.size() == 0 && !in_valid);
    send_idle_pct  = 0;
    recv_stall_pct = 45;
    queue_random(PHASE_ITEMS);

    wait (pending_stamps.size() == 0 && !in_valid);
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    queue_random(PHASE_ITEMS);

    // drain, sampled at clock edges so the last offer is not missed
    @(posedge clk);
    while (pending_stamps.size() != 0 || in_valid || expected_verdicts.size() != 0) begin
      @(posedge clk);
    end
    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_verdicts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (expected_verdicts.size() != 0) begin
        $error("%0d expected results never arrived", expected_verdicts.size());
      end
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
